>>> hw/rtl/cfi_pkg.sv
// cfi_pkg: shared widths, constants and register indexes of the feathered circle influence unit
// no dependencies; imported by circle_feather_influence_unit and tb_top
package cfi_pkg;

   localparam int COORD_BITS     = 24;
   localparam int FRAC_BITS      = 16;
   localparam int MAG_BITS       = COORD_BITS - 1;        // |dx|, |dy|, radius, inner radius
   localparam int SQ_BITS        = 2 * MAG_BITS;          // one square, r2, inner
   localparam int D2_BITS        = SQ_BITS + 1;           // sum of two squares
   localparam int INFL_BITS      = FRAC_BITS + 1;         // Q0.16 with room for 1.0
   localparam int PROD_BITS      = INFL_BITS + MAG_BITS;  // (1 - feather) * radius
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = FRAC_BITS / BITS_PER_STAGE;
   localparam int N_STAGES       = DIV_STAGES + 5;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [INFL_BITS-1:0] ONE_VAL = INFL_BITS'(1) << FRAC_BITS;

   // pipeline stage positions
   localparam int S_DIFF  = 0;
   localparam int S_SQ    = 1;
   localparam int S_SUM   = 2;
   localparam int S_CLASS = 3;
   localparam int S_OUT   = N_STAGES - 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2,
      CSR_FEATHER  = 2'd3
   } csr_index_type;

endpackage

>>> hw/rtl/circle_feather_influence_unit.sv
// circle_feather_influence_unit: pipelined feathered circle influence of a query point
// depends on cfi_pkg (widths, constants, register indexes)
//
// usage
//   configuration: csr_we writes csr_wdata into register csr_index at the clock edge
//     (0 center x, 1 center y, 2 radius, 3 feather). write only while the unit is
//     empty; derived values (r squared, inner radius squared, divisor) settle through
//     a short register chain that is always ahead of the first transaction after a write
//   input: one point per transaction on req_valid/req_ready (signed Q15.8 coordinates)
//   output: one result per transaction on rsp_valid/rsp_ready, in order: influence in
//     Q0.16 (65536 = full) and inside_res, set when influence is nonzero
//   pipeline: the accepting edge loads the first of 13 register stages (difference,
//     squares, sum, classify, eight 2-bit divider stages, output)
//   throughput: one transaction per cycle when the output is not stalled; the ramp
//     division is a restoring divider unrolled into eight stages of two quotient bits each
//   stall: each stage moves when its successor is empty or moving, so bubbles
//     are squeezed out and req_ready drops only when every stage holds a transaction
//   reset: synchronous, active high; empties the pipeline and clears the
//     configuration registers and the derived values to 0
module circle_feather_influence_unit
   import cfi_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [COORD_BITS-1:0]     csr_wdata,
   // requests
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   // responses
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [INFL_BITS-1:0]      rsp_influence,
   output logic                      rsp_inside_res
);

   // ---------------------------------------------------------------
   // configuration registers
   // ---------------------------------------------------------------
   logic [COORD_BITS-1:0] center_x_ff, center_y_ff;
   logic [MAG_BITS-1:0]   radius_ff;
   logic [INFL_BITS-1:0]  feather_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
         feather_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[MAG_BITS-1:0];
            CSR_FEATHER:  feather_ff  <= csr_wdata[INFL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // derived configuration: r2 and inner radius registered from radius and feather,
   // inner from the inner radius, divisor from r2 and inner; first use is in the classify
   // stage (inner, r2) and the divider (divisor), which a transaction reaches later
   // ---------------------------------------------------------------
   logic [INFL_BITS-1:0] feather_clamped;
   logic [PROD_BITS-1:0] ri_prod;
   logic [SQ_BITS-1:0]   r2_ff, inner_ff, den_ff;
   logic [MAG_BITS-1:0]  ri_ff;

   always_comb begin
      feather_clamped = (feather_ff > ONE_VAL) ? ONE_VAL : feather_ff;
      ri_prod         = PROD_BITS'(ONE_VAL - feather_clamped) * PROD_BITS'(radius_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r2_ff    <= '0;
         ri_ff    <= '0;
         inner_ff <= '0;
         den_ff   <= '0;
      end else begin
         r2_ff    <= SQ_BITS'(radius_ff) * SQ_BITS'(radius_ff);
         ri_ff    <= ri_prod[FRAC_BITS +: MAG_BITS];   // truncated, never above radius
         inner_ff <= SQ_BITS'(ri_ff) * SQ_BITS'(ri_ff);
         den_ff   <= r2_ff - inner_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage handshake: a stage loads when it is empty or its content moves on
   // ---------------------------------------------------------------
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES:0]   en;

   always_comb begin
      en[N_STAGES] = rsp_ready;
      for (int k = N_STAGES - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < N_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_ready = en[0];

   // ---------------------------------------------------------------
   // stage 0: absolute coordinate differences and far-point flag
   // ---------------------------------------------------------------
   logic [COORD_BITS:0] dx_in, dy_in, ux_in, uy_in;
   logic [MAG_BITS-1:0] ax_ff, ay_ff;
   logic                far_in;
   logic                far0_ff;

   always_comb begin
      dx_in  = {center_x_ff[COORD_BITS-1], center_x_ff}
             - {req_point_x[COORD_BITS-1], req_point_x};
      dy_in  = {center_y_ff[COORD_BITS-1], center_y_ff}
             - {req_point_y[COORD_BITS-1], req_point_y};
      ux_in  = dx_in[COORD_BITS] ? (~dx_in + 1'b1) : dx_in;
      uy_in  = dy_in[COORD_BITS] ? (~dy_in + 1'b1) : dy_in;
      // beyond any radius the register can hold
      far_in = (|ux_in[COORD_BITS:MAG_BITS]) || (|uy_in[COORD_BITS:MAG_BITS]);
   end

   always_ff @(posedge clock) begin
      if (en[S_DIFF]) begin
         ax_ff   <= ux_in[MAG_BITS-1:0];
         ay_ff   <= uy_in[MAG_BITS-1:0];
         far0_ff <= far_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: squares
   // ---------------------------------------------------------------
   logic [SQ_BITS-1:0] sqx_ff, sqy_ff;
   logic               far1_ff;

   always_ff @(posedge clock) begin
      if (en[S_SQ]) begin
         sqx_ff  <= SQ_BITS'(ax_ff) * SQ_BITS'(ax_ff);
         sqy_ff  <= SQ_BITS'(ay_ff) * SQ_BITS'(ay_ff);
         far1_ff <= far0_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: squared distance
   // ---------------------------------------------------------------
   logic [D2_BITS-1:0] d2_ff;
   logic               far2_ff;

   always_ff @(posedge clock) begin
      if (en[S_SUM]) begin
         d2_ff   <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         far2_ff <= far1_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: classify (outside, full, ramp) and ramp numerator;
   // a point on the rim that is not full gets zero influence
   // ---------------------------------------------------------------
   logic [D2_BITS-1:0] r2_ext, inner_ext;
   logic               zero_in, full_in;

   // divider arrays: entry 0 is the classify stage, entry j the j-th divider stage
   logic [D2_BITS-1:0]   rem_ff  [DIV_STAGES+1];
   logic [FRAC_BITS-1:0] q_ff    [DIV_STAGES+1];
   logic [DIV_STAGES:0]  zero_ff;
   logic [DIV_STAGES:0]  full_ff;

   always_comb begin
      r2_ext    = {1'b0, r2_ff};
      inner_ext = {1'b0, inner_ff};
      full_in   = d2_ff <= inner_ext;
      zero_in   = far2_ff || (d2_ff > r2_ext) || ((d2_ff == r2_ext) && !full_in);
   end

   always_ff @(posedge clock) begin
      if (en[S_CLASS]) begin
         rem_ff[0]  <= d2_ff - inner_ext;
         q_ff[0]    <= '0;
         zero_ff[0] <= zero_in;
         full_ff[0] <= full_in;
      end
   end

   // ---------------------------------------------------------------
   // stages 4..11: restoring division, two quotient bits per stage
   // ---------------------------------------------------------------
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [D2_BITS-1:0]   rem_in;
      logic [FRAC_BITS-1:0] q_in;
      logic [D2_BITS:0]     trial;

      always_comb begin
         rem_in = rem_ff[j-1];
         q_in   = q_ff[j-1];
         trial  = '0;
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            trial = {rem_in, 1'b0};
            if (trial >= {2'b00, den_ff}) begin
               trial = trial - {2'b00, den_ff};
               q_in  = {q_in[FRAC_BITS-2:0], 1'b1};
            end else begin
               q_in  = {q_in[FRAC_BITS-2:0], 1'b0};
            end
            rem_in = trial[D2_BITS-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en[S_CLASS+j]) begin
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            zero_ff[j] <= zero_ff[j-1];
            full_ff[j] <= full_ff[j-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // output stage: influence = 1 - quotient on the ramp
   // ---------------------------------------------------------------
   logic [INFL_BITS-1:0] influence_in;
   logic [INFL_BITS-1:0] influence_ff;
   logic                 inside_ff;

   always_comb begin
      if (zero_ff[DIV_STAGES]) begin
         influence_in = '0;
      end else if (full_ff[DIV_STAGES]) begin
         influence_in = ONE_VAL;
      end else begin
         influence_in = ONE_VAL - {1'b0, q_ff[DIV_STAGES]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) begin
         influence_ff <= influence_in;
         inside_ff    <= !zero_ff[DIV_STAGES];
      end
   end

   assign rsp_valid      = valid_ff[S_OUT];
   assign rsp_influence  = influence_ff;
   assign rsp_inside_res = inside_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("request stalled while a pipeline stage is empty");

   a_ramp_remainder: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[S_CLASS+DIV_STAGES] && !zero_ff[DIV_STAGES] && !full_ff[DIV_STAGES])
      |-> ({1'b0, rem_ff[DIV_STAGES]} < {2'b00, den_ff}))
      else $error("ramp remainder not below divisor");

   a_inside_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_inside_res == (rsp_influence != '0)))
      else $error("inside flag disagrees with influence");

   a_influence_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_influence <= ONE_VAL))
      else $error("influence above full scale");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench of the feathered circle influence unit
// depends on cfi_pkg (widths, constants, register indexes) and circle_feather_influence_unit
module tb_top;
   import cfi_pkg::*;

   // one query point as it goes onto the request channel
   typedef struct {
      logic [COORD_BITS-1:0] point_x;
      logic [COORD_BITS-1:0] point_y;
   } point_type;

   // predicted weight of one point, the point kept for messages
   typedef struct {
      point_type            point;
      logic [INFL_BITS-1:0] influence;
      logic                 inside_res;
   } weight_type;

   // clock, reset and every block input start at known values
   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_we      = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_CENTER_X;
   logic [COORD_BITS-1:0]     csr_wdata   = '0;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [COORD_BITS-1:0]     req_point_x = '0;
   logic [COORD_BITS-1:0]     req_point_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [INFL_BITS-1:0]      rsp_influence;
   logic                      rsp_inside_res;

   // shadow copy of the circle registers, held at their stored widths
   logic signed [COORD_BITS-1:0] center_x_q = '0;
   logic signed [COORD_BITS-1:0] center_y_q = '0;
   logic [MAG_BITS-1:0]          radius_q   = '0;
   logic [INFL_BITS-1:0]         feather_q  = '0;

   point_type  pending_points[$];    // points waiting for the request channel
   weight_type expected_weights[$];  // weights of accepted points, oldest first
   point_type  next_point;
   bit         quiet_run = 1'b0;     // set: neither side ever idles

   int error_count   = 0;
   int result_count  = 0;
   int full_count    = 0;
   int ramp_count    = 0;
   int zero_count    = 0;
   int setting_count = 0;

   circle_feather_influence_unit dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_influence  (rsp_influence),
      .rsp_inside_res (rsp_inside_res)
   );

   always #5 clock = ~clock;

   // about 17 breaks in a hundred calls unless a quiet run is on
   function automatic bit take_break();
      return !quiet_run && ($urandom_range(99) < 17);
   endfunction

   // weight of a point against the current shadow registers
   function automatic weight_type predict_weight(point_type p);
      logic signed [63:0] dx, dy;
      logic [63:0]        ax, ay, limit, d2, r2, fe, ri, inner, ramp;
      weight_type         w;
      w.point     = p;
      w.influence = '0;
      dx    = $signed(center_x_q) - $signed(p.point_x);
      dy    = $signed(center_y_q) - $signed(p.point_y);
      ax    = (dx < 0) ? -dx : dx;
      ay    = (dy < 0) ? -dy : dy;
      limit = 64'd1 << (COORD_BITS - 1);
      // a distance the coordinate range cannot reach any radius from stays at zero
      if (ax < limit && ay < limit) begin
         d2 = ax * ax + ay * ay;
         r2 = 64'(radius_q) * 64'(radius_q);
         if (d2 <= r2) begin
            // feather above one acts as one
            fe    = (feather_q > ONE_VAL) ? 64'(ONE_VAL) : 64'(feather_q);
            ri    = ((64'(ONE_VAL) - fe) * 64'(radius_q)) >> FRAC_BITS;
            inner = ri * ri;
            if (d2 <= inner) begin
               w.influence = ONE_VAL;
            end else begin
               // truncated quotient, so the weight rounds up; the rim lands on zero
               ramp        = ((d2 - inner) << FRAC_BITS) / (r2 - inner);
               w.influence = INFL_BITS'(64'(ONE_VAL) - ramp);
            end
         end
      end
      w.inside_res = (w.influence != '0);
      return w;
   endfunction

   task automatic report_mismatch(string what, point_type p, longint got, longint want);
      $display("mismatch %s at point (%0d, %0d): got %0d, want %0d", what,
               $signed(p.point_x), $signed(p.point_y), got, want);
      error_count++;
   endtask

   // request driver: presents queued points, holds each until the transaction happens
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_weights.push_back(predict_weight(point_type'{req_point_x, req_point_y}));
         end
         // the channel is free when nothing is shown or the shown point just went
         if (!req_valid || req_ready) begin
            if (pending_points.size() != 0 && !take_break()) begin
               next_point = pending_points.pop_front();
               req_valid   <= 1'b1;
               req_point_x <= next_point.point_x;
               req_point_y <= next_point.point_y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor: checks each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_weights.size() == 0) begin
               report_mismatch("result with nothing outstanding", point_type'{'0, '0},
                               rsp_influence, 0);
            end else begin
               weight_type w;
               w = expected_weights.pop_front();
               result_count++;
               if (w.influence == ONE_VAL)
                  full_count++;
               else if (w.influence == '0)
                  zero_count++;
               else
                  ramp_count++;
               if (rsp_influence !== w.influence)
                  report_mismatch("influence", w.point, rsp_influence, w.influence);
               if (rsp_inside_res !== w.inside_res)
                  report_mismatch("inside_res", w.point, rsp_inside_res, w.inside_res);
            end
         end
         rsp_ready <= !take_break();
      end
   end

   // all four registers, written back to back while the unit is empty;
   // the raw data may carry bits above a register's width, which are dropped
   task automatic write_circle(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                               logic [COORD_BITS-1:0] r_raw, logic [COORD_BITS-1:0] f_raw);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_index <= CSR_RADIUS;
      csr_wdata <= r_raw;
      @(posedge clock);
      csr_index <= CSR_FEATHER;
      csr_wdata <= f_raw;
      @(posedge clock);
      csr_we <= 1'b0;
      center_x_q = cx;
      center_y_q = cy;
      radius_q   = r_raw[MAG_BITS-1:0];
      feather_q  = f_raw[INFL_BITS-1:0];
      setting_count++;
   endtask

   task automatic push_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
      pending_points.push_back(point_type'{x, y});
   endtask

   // wait for every point to go out and every result to come back, then settle
   task automatic drain();
      do @(negedge clock);
      while (pending_points.size() != 0 || req_valid || expected_weights.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // point at a signed offset from the center along one axis, random direction
   function automatic point_type axis_point(int unsigned offset);
      point_type p;
      int        signed_off;
      signed_off = ($urandom_range(1) != 0) ? -int'(offset) : int'(offset);
      p.point_x  = center_x_q;
      p.point_y  = center_y_q;
      if ($urandom_range(1) != 0)
         p.point_x = COORD_BITS'(int'(center_x_q) + signed_off);
      else
         p.point_y = COORD_BITS'(int'(center_y_q) + signed_off);
      return p;
   endfunction

   // mostly points that fall in or near the circle, so the ramp gets real work
   function automatic point_type random_point();
      point_type   p;
      int unsigned reach, pick, ri;
      int          ox, oy;
      reach = radius_q + radius_q / 2 + 2;
      ri    = int'(((64'(ONE_VAL) - ((feather_q > ONE_VAL) ? 64'(ONE_VAL) : 64'(feather_q)))
                    * 64'(radius_q)) >> FRAC_BITS);
      pick  = $urandom_range(99);
      if (pick < 55) begin
         ox        = int'($urandom_range(2 * reach)) - int'(reach);
         oy        = int'($urandom_range(2 * reach)) - int'(reach);
         p.point_x = COORD_BITS'(int'(center_x_q) + ox);
         p.point_y = COORD_BITS'(int'(center_y_q) + oy);
      end else if (pick < 65) begin
         // just around the edge of the full-weight disc
         p = axis_point(ri + $urandom_range(2) - 1);
      end else if (pick < 75) begin
         // just around the rim
         p = axis_point(radius_q + $urandom_range(2) - 1);
      end else if (pick < 80) begin
         p = point_type'{center_x_q, center_y_q};
      end else begin
         p.point_x = COORD_BITS'($urandom);
         p.point_y = COORD_BITS'($urandom);
      end
      return p;
   endfunction

   // stimulus: directed settings first, then random settings with random points
   initial begin
      logic [COORD_BITS-1:0] cx, cy, r_raw, f_raw;
      logic [INFL_BITS-1:0]  fe;
      logic [MAG_BITS-1:0]   rad;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // registers still at reset: zero radius, only the exact center counts
      push_point(24'd0, 24'd0);
      push_point(24'd1, 24'd0);
      push_point(24'd0, 24'hFFFFFF);
      push_point(24'h800000, 24'h800000);
      push_point(24'h7FFFFF, 24'd0);
      drain();

      // radius 100.0, feather one quarter: full disc to 75.0, ramp beyond
      write_circle(24'd0, 24'd0, 24'd25600, 24'd16384);
      push_point(24'd0, 24'd0);
      push_point(24'd25600, 24'd0);        // on the rim
      push_point(24'd0, -24'sd25600);      // on the rim, negative side
      push_point(24'd19200, 24'd0);        // edge of the full disc
      push_point(24'd19201, 24'd0);
      push_point(24'd20000, 24'd10000);
      push_point(24'd25601, 24'd0);        // just outside
      push_point(24'd18000, 24'd9000);
      push_point(24'd10000, 24'd10000);
      push_point(24'h7FFFFF, 24'h800000);  // far point
      drain();

      // extreme center and radius, feather one: the ramp spans the whole circle
      write_circle(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'd65536);
      push_point(24'h7FFFFF, 24'h7FFFFF);  // distance past the coordinate range
      push_point(24'h800000, 24'h7FFFFF);  // at the center
      push_point(24'd0, 24'h7FFFFF);       // distance exactly at the range limit
      push_point(24'hFFFFFF, 24'h7FFFFF);  // on the largest rim
      push_point(24'h800001, 24'h7FFFFE);
      drain();

      // feather above one with junk above the register widths
      write_circle(24'd0, 24'd0, 24'h800100, 24'hFFFFFF);
      push_point(24'd128, 24'd0);
      push_point(24'd0, 24'd0);
      push_point(24'd256, 24'd0);
      drain();

      // feather zero: the whole disc is full, the rim too
      write_circle(24'd0, 24'd0, 24'd256, 24'd0);
      push_point(24'd256, 24'd0);
      push_point(24'd257, 24'd0);
      drain();

      for (int phase_n = 0; phase_n < 8; phase_n++) begin
         cx = ($urandom_range(99) < 70) ? COORD_BITS'(int'($urandom_range(65536)) - 32768)
                                        : COORD_BITS'($urandom);
         cy = ($urandom_range(99) < 70) ? COORD_BITS'(int'($urandom_range(65536)) - 32768)
                                        : COORD_BITS'($urandom);
         case ($urandom_range(3))
            0: rad = MAG_BITS'($urandom_range(4096));
            1: rad = MAG_BITS'($urandom);
            2: rad = {MAG_BITS{1'b1}};
            default: rad = MAG_BITS'($urandom_range(65536));
         endcase
         case ($urandom_range(5))
            0: fe = '0;
            1: fe = ONE_VAL;
            2: fe = INFL_BITS'($urandom_range(131071, 65537));
            default: fe = INFL_BITS'($urandom_range(65536));
         endcase
         r_raw = {1'($urandom), rad};
         f_raw = {7'($urandom), fe};
         write_circle(cx, cy, r_raw, f_raw);
         // one whole setting runs with both sides streaming back to back
         quiet_run <= (phase_n == 3);
         for (int n = 0; n < 190; n++)
            pending_points.push_back(random_point());
         drain();
         quiet_run <= 1'b0;
      end

      $display("covered %0d circle settings, %0d results checked", setting_count, result_count);
      $display("weights seen: %0d full, %0d on the ramp, %0d zero; %0d mismatches",
               full_count, ramp_count, zero_count, error_count);
      if (error_count == 0 && expected_weights.size() == 0) begin
         $display("circle_feather_influence_unit test passed");
      end else begin
         $display("circle_feather_influence_unit test failed");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #2000000;
      $display("circle_feather_influence_unit test failed");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/cfi_pkg.sv
hw/rtl/circle_feather_influence_unit.sv
dv/tb_top.sv
